// ===== rtl/gfse_pkg.sv =====
// Shared types, constants and helpers for the grip force slip error block.
// Used by the controller, datapath and arithmetic units; depends on nothing.
package gfse_pkg;

  // Fixed widths of the arithmetic units
  localparam int unsigned DivW    = 49;   // dividend and quotient bits
  localparam int unsigned DvsW    = 34;   // divisor bits
  localparam int unsigned DivCntW = 6;    // step counter for DivW steps

  localparam logic [30:0] Mag31Max = 31'h7FFF_FFFF;
  localparam logic [31:0] Pos32Max = 32'h7FFF_FFFF;
  localparam logic [31:0] Neg32Min = 32'h8000_0000;

  // Register indexes of the configuration port
  typedef enum logic {
    CFG_FRICTION   = 1'b0,
    CFG_MIN_NORMAL = 1'b1
  } cfg_idx_e;

  // Operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MS_SQ_A,   // square of a scaled force magnitude
    MS_DOT,    // normal component times force component
    MS_PROJ,   // normal force times normal component
    MS_SQ_T    // square of a tangential magnitude
  } mul_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic       shift;
    logic       acc_clr;
    logic       mul_en;
    mul_sel_e   mul_sel;
    logic       acc_add;
    logic       nf_ld;
    logic       t_ld;
    logic       sqrt_start;
    logic       div_start;
    logic       div_latch;
    logic       dir_ld;
    logic       dir_clr;
    logic       tang_ld;
    logic       des_ld;
    logic       out_ld;
    logic [1:0] idx;
  } gfse_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mag_zero;
    logic mag_norm;
    logic sqrt_done;
    logic div_done;
    logic mu_zero;
  } gfse_sts_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [50:0] v);
    logic [31:0] res;
    if (v > 51'sd2147483647) begin
      res = Pos32Max;
    end else if (v < -51'sd2147483648) begin
      res = Neg32Min;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/grip_force_slip_error.sv =====
// Grip force error from a friction cone for one 3-axis force sensor.
// Top level: ties the controller and the datapath to the stream and config ports.
// One item is one force sample. The first sample after reset latches the unit
// contact normal and gives no result; every later sample gives one result beat.
// A result sample runs the 32-step square root and, unless the friction is zero,
// the 49-step divider; both work one bit per cycle. The first sample runs the
// normalizing shift and, unless its magnitude is zero, the root and one 49-step
// divide per axis. One sample is in work at a time;
// the next is accepted while a finished result still waits on the output.
// Config writes are taken at any time but belong between samples.
module grip_force_slip_error (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // force_x [31:0], force_y [63:32], force_z [95:64]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // grip_error [31:0], desired [63:32], normal_force [95:64],
  // tangential_magnitude [126:96], dir_x [142:127], dir_y [158:143],
  // dir_z [174:159], zero [175]
  output logic [175:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import gfse_pkg::*;

  gfse_cmd_t cmd;
  gfse_sts_t sts;

  assign cfg_ready_o = 1'b1;

  gfse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gfse_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .force_i     (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/gfse_sqrt.sv =====
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
// Gives floor root and remainder; depends on nothing.
module gfse_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o,
  output logic [32:0] rem_o
);

  logic [63:0] v_q, r_q, bit_q;
  logic [63:0] trial;
  logic        busy_q, done_q;

  assign trial = r_q + bit_q;

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // One root bit per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];
  assign rem_o  = v_q[32:0];

endmodule

// ===== rtl/gfse_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gfse_pkg for its widths.
module gfse_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gfse_pkg::DivW-1:0] dividend_i,
  input  logic [gfse_pkg::DvsW-1:0] divisor_i,
  output logic                      done_o,
  output logic [gfse_pkg::DivW-1:0] quot_o
);
  import gfse_pkg::*;

  logic [DivW-1:0]    dq_q;
  logic [DvsW-1:0]    rem_q, dvs_q;
  logic [DvsW:0]      rem_sh;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic               q_bit;

  assign rem_sh = {rem_q, dq_q[DivW-1]};
  assign q_bit  = rem_sh >= {1'b0, dvs_q};

  // Step count and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift dividend out, quotient in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= q_bit ? DvsW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DvsW-1:0];
      dq_q  <= {dq_q[DivW-2:0], q_bit};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

// ===== rtl/gfse_dp.sv =====
// Datapath: force registers, shared multiplier, accumulator, config registers,
// result register. Depends on gfse_pkg, gfse_sqrt and gfse_div.
module gfse_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gfse_pkg::gfse_cmd_t cmd_i,
  output gfse_pkg::gfse_sts_t sts_o,
  input  logic [95:0]         force_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic [175:0]        out_data_o
);
  import gfse_pkg::*;

  logic signed [31:0] f_q [3];
  logic        [31:0] a_q [3];
  logic signed [15:0] dir_q [3];
  logic        [30:0] tm_q [3];
  logic signed [65:0] acc_q, prod_q;
  logic signed [35:0] nf_q;
  logic               huge_q;
  logic        [30:0] tang_q;
  logic signed [49:0] des_q;
  logic        [23:0] mu_q;
  logic        [30:0] margin_q;
  logic       [175:0] out_q;

  logic signed [36:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [69:0] mul_p;
  logic        [31:0] a_or;
  logic signed [37:0] proj_r;
  logic signed [38:0] t_val, t_mag;
  logic        [31:0] sq_root;
  logic        [32:0] sq_rem;
  logic        [32:0] root_rnd;
  logic               sqrt_done, div_done;
  logic [DivW-1:0]    div_dvd, div_quot;
  logic [DvsW-1:0]    div_dvs;
  logic signed [15:0] q_dir;
  logic signed [50:0] err;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q     <= 24'd65536;
      margin_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRICTION:   mu_q     <= cfg_data_i[23:0];
        CFG_MIN_NORMAL: margin_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      MS_SQ_A: begin
        mul_a = 37'({5'b0, a_q[cmd_i.idx]});
        mul_b = {1'b0, a_q[cmd_i.idx]};
      end
      MS_DOT: begin
        mul_a = 37'(dir_q[cmd_i.idx]);
        mul_b = 33'(f_q[cmd_i.idx]);
      end
      MS_PROJ: begin
        mul_a = 37'(nf_q);
        mul_b = 33'(dir_q[cmd_i.idx]);
      end
      MS_SQ_T: begin
        mul_a = {6'b0, tm_q[cmd_i.idx]};
        mul_b = {2'b0, tm_q[cmd_i.idx]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign a_or  = a_q[0] | a_q[1] | a_q[2];

  // Tangential component: force minus rounded projection
  assign proj_r = 38'((prod_q + 66'sd8192) >>> 14);
  assign t_val  = 39'(f_q[cmd_i.idx]) - 39'(proj_r);
  assign t_mag  = t_val[38] ? -t_val : t_val;

  // Root rounded to nearest
  assign root_rnd = {1'b0, sq_root} + 33'(sq_rem > {1'b0, sq_root});

  // Divider operands: normal latch or desired force
  always_comb begin
    if (cmd_i.div_latch) begin
      div_dvd = DivW'({a_q[cmd_i.idx], 15'b0}) + DivW'(sq_root);
      div_dvs = DvsW'({sq_root, 1'b0});
    end else begin
      div_dvd = DivW'({tang_q, 17'b0}) + DivW'(mu_q);
      div_dvs = DvsW'({mu_q, 1'b0});
    end
  end

  assign q_dir = $signed(div_quot[15:0]);
  assign err   = 51'(des_q) - 51'(nf_q);

  gfse_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (acc_q[63:0]),
    .done_o  (sqrt_done),
    .root_o  (sq_root),
    .rem_o   (sq_rem)
  );

  gfse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Huge-tangential flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      huge_q <= 1'b0;
    end else if (cmd_i.load_in) begin
      huge_q <= 1'b0;
    end else if (cmd_i.t_ld && (t_mag > 39'(Mag31Max))) begin
      huge_q <= 1'b1;
    end
  end

  // Latched normal, cleared at reset and on a zero-magnitude first sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) dir_q[i] <= '0;
    end else if (cmd_i.dir_clr) begin
      for (int i = 0; i < 3; i++) dir_q[i] <= '0;
    end else if (cmd_i.dir_ld) begin
      dir_q[cmd_i.idx] <= f_q[cmd_i.idx][31] ? -q_dir : q_dir;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      for (int i = 0; i < 3; i++) begin
        f_q[i] <= force_i[32*i +: 32];
        a_q[i] <= force_i[32*i+31] ? 32'(-force_i[32*i +: 32]) : force_i[32*i +: 32];
      end
    end else if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
    end
    if (cmd_i.mul_en) prod_q <= 66'(mul_p);
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.nf_ld) nf_q <= 36'((acc_q + 66'sd8192) >>> 14);
    if (cmd_i.t_ld) begin
      tm_q[cmd_i.idx] <= (t_mag > 39'(Mag31Max)) ? '0 : t_mag[30:0];
    end
    if (cmd_i.tang_ld) begin
      tang_q <= (huge_q || (root_rnd > 33'(Mag31Max))) ? Mag31Max : root_rnd[30:0];
    end
    if (cmd_i.des_ld) begin
      des_q <= (mu_q == '0) ? 50'(Pos32Max) : 50'(div_quot[47:0]) + 50'(margin_q);
    end
    if (cmd_i.out_ld) begin
      out_q <= {1'b0, dir_q[2], dir_q[1], dir_q[0], tang_q,
                sat32(51'(nf_q)), sat32(51'(des_q)), sat32(err)};
    end
  end

  assign sts_o.mag_zero  = (a_or == '0);
  assign sts_o.mag_norm  = |a_or[31:30];
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.mu_zero   = (mu_q == '0);
  assign out_data_o      = out_q;

endmodule

// ===== rtl/gfse_ctrl.sv =====
// Controller state machine: sequences the datapath for each force sample and
// runs the input and output handshakes. Depends on gfse_pkg.
module gfse_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  gfse_pkg::gfse_sts_t sts_i,
  output gfse_pkg::gfse_cmd_t cmd_o
);
  import gfse_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NORM, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT_GO, ST_SQRT_WAIT,
    ST_LDIV_GO, ST_LDIV_WAIT, ST_DOT_MUL, ST_DOT_ACC, ST_NF, ST_PRJ_MUL,
    ST_PRJ_T, ST_TANG, ST_DDIV_GO, ST_DDIV_WAIT, ST_DES, ST_OUT
  } state_e;

  state_e     state_q;
  logic [1:0] idx_q;
  logic       first_q;
  logic       out_valid_q;
  logic       accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Decode commands from state
  always_comb begin
    cmd_o         = '0;
    cmd_o.idx     = idx_q;
    cmd_o.mul_sel = MS_DOT;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_in = accept;
        cmd_o.acc_clr = accept;
      end
      ST_NORM: begin
        cmd_o.dir_clr = sts_i.mag_zero;
        cmd_o.acc_clr = !sts_i.mag_zero && sts_i.mag_norm;
        cmd_o.shift   = !sts_i.mag_zero && !sts_i.mag_norm;
      end
      ST_SQ_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = first_q ? MS_SQ_A : MS_SQ_T;
      end
      ST_SQ_ACC:    cmd_o.acc_add = 1'b1;
      ST_SQRT_GO:   cmd_o.sqrt_start = 1'b1;
      ST_LDIV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_latch = 1'b1;
      end
      ST_LDIV_WAIT: begin
        cmd_o.div_latch = 1'b1;
        cmd_o.dir_ld    = sts_i.div_done;
      end
      ST_DOT_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_DOT;
      end
      ST_DOT_ACC:   cmd_o.acc_add = 1'b1;
      ST_NF:        cmd_o.nf_ld = 1'b1;
      ST_PRJ_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_PROJ;
      end
      ST_PRJ_T: begin
        cmd_o.t_ld    = 1'b1;
        cmd_o.acc_clr = (idx_q == 2'd2);
      end
      ST_TANG:      cmd_o.tang_ld = 1'b1;
      ST_DDIV_GO:   cmd_o.div_start = 1'b1;
      ST_DES:       cmd_o.des_ld = 1'b1;
      ST_OUT:       cmd_o.out_ld = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // State, index, first-sample flag and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (accept) state_q <= first_q ? ST_NORM : ST_DOT_MUL;
        end
        ST_NORM: begin
          if (sts_i.mag_zero) begin
            first_q <= 1'b0;
            state_q <= ST_IDLE;
          end else if (sts_i.mag_norm) begin
            state_q <= ST_SQ_MUL;
          end
        end
        ST_SQ_MUL: state_q <= ST_SQ_ACC;
        ST_SQ_ACC: begin
          if (idx_q == 2'd2) begin
            idx_q   <= '0;
            state_q <= ST_SQRT_GO;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_SQ_MUL;
          end
        end
        ST_SQRT_GO: state_q <= ST_SQRT_WAIT;
        ST_SQRT_WAIT: begin
          if (sts_i.sqrt_done) state_q <= first_q ? ST_LDIV_GO : ST_TANG;
        end
        ST_LDIV_GO: state_q <= ST_LDIV_WAIT;
        ST_LDIV_WAIT: begin
          if (sts_i.div_done) begin
            if (idx_q == 2'd2) begin
              first_q <= 1'b0;
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_LDIV_GO;
            end
          end
        end
        ST_DOT_MUL: state_q <= ST_DOT_ACC;
        ST_DOT_ACC: begin
          if (idx_q == 2'd2) begin
            idx_q   <= '0;
            state_q <= ST_NF;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_DOT_MUL;
          end
        end
        ST_NF:      state_q <= ST_PRJ_MUL;
        ST_PRJ_MUL: state_q <= ST_PRJ_T;
        ST_PRJ_T: begin
          if (idx_q == 2'd2) begin
            idx_q   <= '0;
            state_q <= ST_SQ_MUL;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_PRJ_MUL;
          end
        end
        ST_TANG:      state_q <= sts_i.mu_zero ? ST_DES : ST_DDIV_GO;
        ST_DDIV_GO:   state_q <= ST_DDIV_WAIT;
        ST_DDIV_WAIT: if (sts_i.div_done) state_q <= ST_DES;
        ST_DES:       state_q <= ST_OUT;
        ST_OUT:       if (cmd_o.out_ld) state_q <= ST_IDLE;
        default:      state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while pending");

  // The normal is written only while the first sample is handled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.dir_ld || cmd_o.dir_clr) |-> first_q)
    else $error("normal written after first sample");

  // One item at a time: no new beat right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input accepted while busy");

  // The first sample never yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> !first_q)
    else $error("result produced for first sample");
`endif

endmodule
